>>> rtl/ppg_pkg.sv
// shared types, sine table contents and constants of the plasma pixel generator
`timescale 1ns / 1ps
`default_nettype none

package ppg_pkg;

    localparam int TABLE_DEPTH = 4096;
    localparam int ROM_AW      = $clog2(TABLE_DEPTH);
    localparam int COORD_W     = 10;
    localparam int PHASE_W     = 10;
    localparam int STEP_W      = 6;
    localparam int WRAP_W      = 11;
    localparam int CFG_AW      = 2;
    localparam int COLOR_W     = 8;

    localparam logic [CFG_AW-1:0] CFG_PHASE_STEP  = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_WRAP_FIRST  = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_WRAP_SECOND = 2'd2;

    localparam logic [STEP_W-1:0] STEP_RESET        = 6'd4;
    localparam logic [WRAP_W-1:0] WRAP_FIRST_RESET  = 11'd503;
    localparam logic [WRAP_W-1:0] WRAP_SECOND_RESET = 11'd880;
    localparam logic [WRAP_W-1:0] WRAP_MIN          = 11'd256;
    localparam logic [WRAP_W-1:0] WRAP_MAX          = 11'd1024;

    typedef logic [COLOR_W-1:0] t_rom [TABLE_DEPTH];

    typedef struct packed {
        logic [ROM_AW-1:0] a;
        logic [ROM_AW-1:0] b;
        logic [ROM_AW-1:0] c;
    } t_rom_addr;

    typedef struct packed {
        logic [COLOR_W-1:0] a;
        logic [COLOR_W-1:0] b;
        logic [COLOR_W-1:0] c;
    } t_sine_vals;

    // pi in q48 with its double and half, from the q60 value
    localparam longint unsigned PI_Q48      = 64'h0003_243F_6A88_85A3;
    localparam longint unsigned TWO_PI_Q48  = 64'h0006_487E_D511_0B46;
    localparam longint unsigned HALF_PI_Q48 = 64'h0001_921F_B544_42D1;

    localparam int SINE_A = 0;
    localparam int SINE_B = 1;
    localparam int SINE_C = 2;

    localparam longint unsigned DIV_A = 64'd60;
    localparam longint unsigned DIV_B = 64'd80;
    localparam longint unsigned DIV_C = 64'd140;
    localparam longint unsigned MOD_A = DIV_A * TWO_PI_Q48;
    localparam longint unsigned MOD_B = DIV_B * TWO_PI_Q48;
    localparam longint unsigned MOD_C = DIV_C * TWO_PI_Q48;

    localparam longint AMP_A = 64'sd96;
    localparam longint AMP_B = 64'sd112;
    localparam longint AMP_C = 64'sd128;

    // taylor denominators (2k)(2k+1)
    localparam longint unsigned TAYLOR_DIV [20] = '{
        64'd1, 64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210,
        64'd272, 64'd342, 64'd420, 64'd506, 64'd600, 64'd702, 64'd812,
        64'd930, 64'd1056, 64'd1190, 64'd1332, 64'd1482
    };

    // sine in q30 of i over the table divisor, truncated at every product
    function automatic longint sine_q30(input longint unsigned i, input int sel);
        longint unsigned t;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        logic            neg;
        neg = 1'b0;
        case (sel)
            SINE_A:  t = ((i << 48) % MOD_A) / DIV_A;
            SINE_B:  t = ((i << 48) % MOD_B) / DIV_B;
            default: t = ((i << 48) % MOD_C) / DIV_C;
        endcase
        if (t >= TWO_PI_Q48) t = t - TWO_PI_Q48;
        if (t >= PI_Q48) begin
            t   = t - PI_Q48;
            neg = 1'b1;
        end
        if (t > PI_Q48) t = PI_Q48;
        if (t > HALF_PI_Q48) t = PI_Q48 - t;
        x    = t >> 18;
        x2   = (x * x) >> 30;
        sum  = longint'(x);
        term = x;
        for (int k = 1; k < 20; k++) begin
            term = ((term * x2) >> 30) / TAYLOR_DIV[k];
            if ((k % 2) == 1) sum = sum - longint'(term);
            else              sum = sum + longint'(term);
        end
        return neg ? -sum : sum;
    endfunction

    // one table entry: floor(amp + amp*sin), held in [0, 2*amp-1]
    function automatic logic [COLOR_W-1:0] rom_entry(input int i, input int sel);
        longint amp;
        longint v;
        case (sel)
            SINE_A:  amp = AMP_A;
            SINE_B:  amp = AMP_B;
            default: amp = AMP_C;
        endcase
        v = amp * (64'sd1 <<< 30) + amp * sine_q30(longint'(i), sel);
        if (v < 0) v = 0;
        v = v >>> 30;
        if (v > 2 * amp - 1) v = 2 * amp - 1;
        return v[COLOR_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> rtl/ppg_phase.sv
// configuration registers, frame phase accumulators and sine table addresses
`timescale 1ns / 1ps
`default_nettype none

module ppg_phase
    import ppg_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [CFG_AW-1:0]  i_cfg_addr,
    input  wire logic [WRAP_W-1:0]  i_cfg_wdata,
    input  wire logic               i_accept,
    input  wire logic [COORD_W-1:0] i_pixel_x,
    input  wire logic [COORD_W-1:0] i_pixel_y,
    input  wire logic               i_frame_start,
    output t_rom_addr               o_addr
);

    logic [STEP_W-1:0]  r_step;
    logic [WRAP_W-1:0]  r_wrap_first;
    logic [WRAP_W-1:0]  r_wrap_second;
    logic [PHASE_W-1:0] r_phase_v;
    logic [PHASE_W-1:0] r_phase_d;
    logic [PHASE_W-1:0] n_phase_v;
    logic [PHASE_W-1:0] n_phase_d;
    logic [PHASE_W-1:0] phase_v_use;
    logic [PHASE_W-1:0] phase_d_use;
    logic [WRAP_W-1:0]  wrap_v;
    logic [WRAP_W-1:0]  wrap_d;
    logic [STEP_W+1:0]  step3;

    function automatic logic [WRAP_W-1:0] sat_wrap(input logic [WRAP_W-1:0] w);
        if (w < WRAP_MIN)      return WRAP_MIN;
        else if (w > WRAP_MAX) return WRAP_MAX;
        else                   return w;
    endfunction

    // sum stays below five times the smallest wrap, so four subtracts suffice
    function automatic logic [PHASE_W-1:0] wrap_mod(input logic [WRAP_W-1:0] s,
                                                    input logic [WRAP_W-1:0] w);
        logic [WRAP_W-1:0] v;
        v = s;
        for (int k = 0; k < 4; k++) begin
            if (v >= w) v = v - w;
        end
        return v[PHASE_W-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step        <= STEP_RESET;
            r_wrap_first  <= WRAP_FIRST_RESET;
            r_wrap_second <= WRAP_SECOND_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_PHASE_STEP:  r_step        <= i_cfg_wdata[STEP_W-1:0];
                CFG_WRAP_FIRST:  r_wrap_first  <= i_cfg_wdata;
                CFG_WRAP_SECOND: r_wrap_second <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign wrap_v = sat_wrap(r_wrap_first);
    assign wrap_d = sat_wrap(r_wrap_second);
    assign step3  = {2'b00, r_step} + {1'b0, r_step, 1'b0};

    assign n_phase_v = wrap_mod({1'b0, r_phase_v} + WRAP_W'(r_step), wrap_v);
    assign n_phase_d = wrap_mod({1'b0, r_phase_d} + WRAP_W'(step3), wrap_d);

    assign phase_v_use = i_frame_start ? n_phase_v : r_phase_v;
    assign phase_d_use = i_frame_start ? n_phase_d : r_phase_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_v <= '0;
            r_phase_d <= '0;
        end else if (i_accept && i_frame_start) begin
            r_phase_v <= n_phase_v;
            r_phase_d <= n_phase_d;
        end
    end

    assign o_addr.a = ROM_AW'(i_pixel_x);
    assign o_addr.b = ROM_AW'({1'b0, i_pixel_y} + {1'b0, phase_v_use});
    assign o_addr.c = ROM_AW'({2'b00, i_pixel_x} + {2'b00, i_pixel_y} + {2'b00, phase_d_use});

endmodule

`default_nettype wire

>>> rtl/ppg_sine_rom.sv
// three sine tables with registered reads
`timescale 1ns / 1ps
`default_nettype none

module ppg_sine_rom
    import ppg_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_en,
    input  wire t_rom_addr i_addr,
    output t_sine_vals     o_vals
);

    t_rom               rom_a;
    t_rom               rom_b;
    t_rom               rom_c;
    logic [COLOR_W-1:0] r_a;
    logic [COLOR_W-1:0] r_b;
    logic [COLOR_W-1:0] r_c;

    // table contents are fixed from start-up on
    initial begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            rom_a[i] = rom_entry(i, SINE_A);
            rom_b[i] = rom_entry(i, SINE_B);
            rom_c[i] = rom_entry(i, SINE_C);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a <= rom_a[i_addr.a];
            r_b <= rom_b[i_addr.b];
            r_c <= rom_c[i_addr.c];
        end
    end

    assign o_vals.a = r_a;
    assign o_vals.b = r_b;
    assign o_vals.c = r_c;

endmodule

`default_nettype wire

>>> rtl/ppg_color.sv
// sine sum, four segment palette and output register
`timescale 1ns / 1ps
`default_nettype none

module ppg_color
    import ppg_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire t_sine_vals         i_vals,
    output logic [4*COLOR_W-1:0]    o_data
);

    localparam logic [1:0] SEG_RISE  = 2'd0;
    localparam logic [1:0] SEG_WARM  = 2'd1;
    localparam logic [1:0] SEG_BRIGHT = 2'd2;
    localparam logic [1:0] SEG_FADE  = 2'd3;

    logic [COLOR_W-1:0] idx;
    logic [5:0]         j;
    logic [COLOR_W-1:0] j2;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic [4*COLOR_W-1:0] r_data;

    assign idx = i_vals.a + i_vals.b + i_vals.c;
    assign j   = idx[5:0];
    assign j2  = {1'b0, j, 1'b0};

    always_comb begin
        unique case (idx[7:6])
            SEG_RISE: begin
                red   = {j, 2'b00};
                green = j2;
                blue  = '0;
            end
            SEG_WARM: begin
                red   = ~j2;
                green = {1'b1, j, 1'b0};
                blue  = {j, 2'b00};
            end
            SEG_BRIGHT: begin
                red   = {1'b0, ~j, 1'b0};
                green = ~j2;
                blue  = 8'd255;
            end
            SEG_FADE: begin
                red   = '0;
                green = 8'd128 - j2;
                blue  = {~j, 2'b00};
            end
            default: begin
                red   = '0;
                green = '0;
                blue  = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= {idx, blue, green, red};
        end
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

>>> rtl/plasma_pixel_generator_top.sv
// plasma pixel generator top level: stream ports and pipeline control
//
//  port group   dir  tdata bits (low first)                 tuser
//  s_axis       in   pixel_x[9:0] pixel_y[19:10] zero pad   frame_start
//  m_axis       out  red green blue palette_index           -
//  cfg          in   phase_step / wrap_first / wrap_second  (write only)
//
// one pixel per cycle sustained while the output accepts; from input to output
// a pixel passes the sine table read register, then the palette output register.
// reset loads the register defaults and clears the phases and all valid flags.
// each stage holds while the next one is full and stalled, so input is still
// taken while a finished pixel waits on the output if the table stage is empty.
`timescale 1ns / 1ps
`default_nettype none

module plasma_pixel_generator_top
    import ppg_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    input  wire logic [23:0]          i_s_axis_tdata,   // pixel_x, pixel_y, pad
    input  wire logic                 i_s_axis_tuser,   // frame_start
    output logic                      o_m_axis_tvalid,
    input  wire logic                 i_m_axis_tready,
    output logic [4*COLOR_W-1:0]      o_m_axis_tdata,   // red, green, blue, palette_index
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_AW-1:0]    i_cfg_addr,
    input  wire logic [WRAP_W-1:0]    i_cfg_wdata
);

    logic       r_rom_valid;
    logic       r_out_valid;
    logic       adv_out;
    logic       adv_rom;
    logic       accept;
    t_rom_addr  addr;
    t_sine_vals vals;

    assign adv_out = !r_out_valid || i_m_axis_tready;
    assign adv_rom = !r_rom_valid || adv_out;
    assign accept  = i_s_axis_tvalid && adv_rom;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rom_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (adv_rom) r_rom_valid <= i_s_axis_tvalid;
            if (adv_out) r_out_valid <= r_rom_valid;
        end
    end

    ppg_phase u_phase (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_accept      (accept),
        .i_pixel_x     (i_s_axis_tdata[COORD_W-1:0]),
        .i_pixel_y     (i_s_axis_tdata[2*COORD_W-1:COORD_W]),
        .i_frame_start (i_s_axis_tuser),
        .o_addr        (addr)
    );

    ppg_sine_rom u_rom (
        .i_clk  (i_clk),
        .i_en   (adv_rom),
        .i_addr (addr),
        .o_vals (vals)
    );

    ppg_color u_color (
        .i_clk  (i_clk),
        .i_en   (adv_out),
        .i_vals (vals),
        .o_data (o_m_axis_tdata)
    );

    assign o_s_axis_tready = adv_rom;
    assign o_m_axis_tvalid = r_out_valid;

endmodule

`default_nettype wire
